@@ sv/tcf_pkg.sv @@
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types and codes for the two-class oldest-first FIFO: request and
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcf_pkg;

	// request codes
	typedef enum logic [1:0] {
		REQ_ENQ     = 2'd0,
		REQ_DEQ_ANY = 2'd1,
		REQ_DEQ_C0  = 2'd2,
		REQ_DEQ_C1  = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;  // capture the request on this edge
		logic exec;  // execute the held request and load the result
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;  // result register full and not taken this cycle
	} dp_stat_t;

endpackage

@@ sv/tcf_ram.sv @@
// ----------------------------------------------------------------------------
// tcf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (read-before-write on an address clash).
// ----------------------------------------------------------------------------
module tcf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// storage write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/tcf_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcf_ctrl
// Request sequencer: takes one request, lets the datapath execute it once
// the head entries have been read and the result register is free.
// ----------------------------------------------------------------------------
module tcf_ctrl
	import tcf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dp_stat_t  dp_stat,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!dp_stat.out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = 1'b1;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = !dp_stat.out_busy;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

@@ sv/tcf_datapath.sv @@
// ----------------------------------------------------------------------------
// tcf_datapath
// Queue pointers, occupancy counts, arrival sequence counter, the two class
// stores and the result register. Picks the older head by the sign of the
// modular stamp difference.
// ----------------------------------------------------------------------------
module tcf_datapath
	import tcf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_WIDTH   = 16,
	parameter int SEQ_WIDTH   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	output dp_stat_t             dp_stat,
	input  logic [1:0]           req_type,
	input  logic                 item_class,
	input  logic [TAG_WIDTH-1:0] item_tag,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [TAG_WIDTH-1:0] out_tag,
	output logic                 out_class,
	output logic                 all_empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int DW = TAG_WIDTH + SEQ_WIDTH;
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

	// held request
	req_t                 req_q;
	logic                 cls_q;
	logic [TAG_WIDTH-1:0] tag_q;

	// queue state
	logic [PW-1:0]        head0_q, head1_q, tail0_q, tail1_q;
	logic [CW-1:0]        cnt0_q, cnt1_q;
	logic [SEQ_WIDTH-1:0] seq_q;

	// result register
	logic                 out_valid_q;
	status_t              status_q;
	logic [TAG_WIDTH-1:0] out_tag_q;
	logic                 out_class_q;
	logic                 all_empty_q;

	// store ports
	logic [DW-1:0]        rd0, rd1, wr_data;
	logic                 push0, push1, pop0, pop1;
	status_t              st_nxt;
	logic [SEQ_WIDTH-1:0] stamp_diff;
	logic                 empty0, empty1;
	logic [CW-1:0]        cnt0_nxt, cnt1_nxt;
	logic [PW-1:0]        head0_inc, head1_inc, tail0_inc, tail1_inc;
	logic [TAG_WIDTH-1:0] tag_nxt;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= req_t'(req_type);
			cls_q <= item_class;
			tag_q <= item_tag;
		end
	end

	// class stores, read address follows the head pointer
	assign wr_data = {tag_q, seq_q};

	tcf_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_store0 (
		.clk     (clk),
		.wr_en   (cmd.exec && push0),
		.wr_addr (tail0_q),
		.wr_data (wr_data),
		.rd_addr (head0_q),
		.rd_data (rd0)
	);

	tcf_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_store1 (
		.clk     (clk),
		.wr_en   (cmd.exec && push1),
		.wr_addr (tail1_q),
		.wr_data (wr_data),
		.rd_addr (head1_q),
		.rd_data (rd1)
	);

	// request decode and head selection
	assign empty0     = (cnt0_q == '0);
	assign empty1     = (cnt1_q == '0);
	assign stamp_diff = rd0[SEQ_WIDTH-1:0] - rd1[SEQ_WIDTH-1:0];

	always_comb begin
		push0  = 1'b0;
		push1  = 1'b0;
		pop0   = 1'b0;
		pop1   = 1'b0;
		st_nxt = STAT_OK;
		unique case (req_q)
			REQ_ENQ: begin
				if (!cls_q) begin
					if (cnt0_q == CNT_FULL) st_nxt = STAT_FULL;
					else push0 = 1'b1;
				end else begin
					if (cnt1_q == CNT_FULL) st_nxt = STAT_FULL;
					else push1 = 1'b1;
				end
			end
			REQ_DEQ_ANY: begin
				if (!empty0 && !empty1) begin
					// equal stamps go to class 1
					if (stamp_diff[SEQ_WIDTH-1]) pop0 = 1'b1;
					else pop1 = 1'b1;
				end else if (!empty0) begin
					pop0 = 1'b1;
				end else if (!empty1) begin
					pop1 = 1'b1;
				end else begin
					st_nxt = STAT_EMPTY;
				end
			end
			REQ_DEQ_C0: begin
				if (!empty0) pop0 = 1'b1;
				else st_nxt = STAT_EMPTY;
			end
			REQ_DEQ_C1: begin
				if (!empty1) pop1 = 1'b1;
				else st_nxt = STAT_EMPTY;
			end
			default: st_nxt = STAT_EMPTY;
		endcase
	end

	// pointer and count updates
	assign head0_inc = (head0_q == PTR_LAST) ? '0 : head0_q + 1'b1;
	assign head1_inc = (head1_q == PTR_LAST) ? '0 : head1_q + 1'b1;
	assign tail0_inc = (tail0_q == PTR_LAST) ? '0 : tail0_q + 1'b1;
	assign tail1_inc = (tail1_q == PTR_LAST) ? '0 : tail1_q + 1'b1;
	assign cnt0_nxt  = cnt0_q + CW'(push0) - CW'(pop0);
	assign cnt1_nxt  = cnt1_q + CW'(push1) - CW'(pop1);
	assign tag_nxt   = pop0 ? rd0[DW-1:SEQ_WIDTH] :
	                   pop1 ? rd1[DW-1:SEQ_WIDTH] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head0_q <= '0;
			head1_q <= '0;
			tail0_q <= '0;
			tail1_q <= '0;
			cnt0_q  <= '0;
			cnt1_q  <= '0;
			seq_q   <= '0;
		end else if (cmd.exec) begin
			cnt0_q <= cnt0_nxt;
			cnt1_q <= cnt1_nxt;
			if (pop0)  head0_q <= head0_inc;
			if (pop1)  head1_q <= head1_inc;
			if (push0) tail0_q <= tail0_inc;
			if (push1) tail1_q <= tail1_inc;
			if (push0 || push1) seq_q <= seq_q + 1'b1;
		end
	end

	// result valid, cleared once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q    <= st_nxt;
			out_tag_q   <= tag_nxt;
			out_class_q <= pop1;
			all_empty_q <= (cnt0_nxt == '0) && (cnt1_nxt == '0);
		end
	end

	assign dp_stat.out_busy = out_valid_q && out_stall;
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign out_tag          = out_tag_q;
	assign out_class        = out_class_q;
	assign all_empty        = all_empty_q;

endmodule

@@ sv/two_class_fifo_oldest_first.sv @@
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two class queues sharing one arrival counter; dequeue-any returns the
// older head by wrap-aware stamp comparison. One result per request.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   req_type, item_class, item_tag
//   out      source     out_valid / out_stall status, out_tag, out_class,
//                                             all_empty
//
// Each request is handled in two steps: a capture step while the head entries
// are read from the class RAMs, and an execute step loading the result register.
// The registered RAM read of the heads is why the two steps are separate.
// A new request is taken while the previous result still waits; execution
// holds while the result register is full and stalled.
// Reset clears pointers, counts and the sequence counter; no clearing pass.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first
	import tcf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_WIDTH   = 16,
	parameter int SEQ_WIDTH   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic                 item_class,
	input  logic [TAG_WIDTH-1:0] item_tag,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [TAG_WIDTH-1:0] out_tag,
	output logic                 out_class,
	output logic                 all_empty
);

	ctrl_cmd_t cmd;
	dp_stat_t  dp_stat;

	// sequencer
	tcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.dp_stat  (dp_stat),
		.cmd      (cmd)
	);

	// queues and result register
	tcf_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_WIDTH   (TAG_WIDTH),
		.SEQ_WIDTH   (SEQ_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dp_stat    (dp_stat),
		.req_type   (req_type),
		.item_class (item_class),
		.item_tag   (item_tag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_tag    (out_tag),
		.out_class  (out_class),
		.all_empty  (all_empty)
	);

	// an execute always leaves a result waiting
	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid)
		else $error("execute without a result");

	// one request at a time: after a transfer in, the input stalls
	a_accept_then_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second request taken before execution");

	// execution never overwrites a stalled result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(out_valid && out_stall))
		else $error("result overwritten while stalled");

	// empty and full results carry no item
	a_no_item_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_EMPTY || status == STAT_FULL))
			|-> (out_tag == '0 && out_class == 1'b0))
		else $error("item returned with a failing status");

endmodule

@@ tb/two_class_fifo_oldest_first_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_tb
// Self-checking testbench for the two-class oldest-first FIFO. A short table
// of directed requests covers empty pops, a full class queue and age order.
// It is followed by random traffic that swings between filling and draining
// phases. Every accepted request is run through a behavioural copy of the
// two queues and the arrival counter. Each result transfer is compared,
// field by field, with the oldest outstanding expected result. Both channels see
// random gaps and stalls.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first_tb;
	import tcf_pkg::*;

	localparam int DEPTH        = 16;
	localparam int TAG_W        = 16;
	localparam int SEQ_W        = 32;
	localparam int RANDOM_ITEMS = 1420;
	localparam int PAUSE_AT     = 700;
	localparam int LONG_HOLD    = 80;
	localparam int HOLD_AFTER   = 300;
	localparam int MAX_REPORTS  = 10;

	// one queued item as the predictor sees it
	typedef struct {
		logic [TAG_W-1:0] tag;
		logic [SEQ_W-1:0] stamp;
	} slot_t;

	// one result transfer
	typedef struct {
		status_t          status;
		logic [TAG_W-1:0] tag;
		logic             cls;
		logic             all_empty;
	} fifo_resp_t;

	// one line of the directed table; exp is used only where typed is set
	typedef struct {
		req_t             req;
		logic             cls;
		logic [TAG_W-1:0] tag;
		int               reps;
		bit               typed;
		fifo_resp_t       exp;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       req_type;
	logic             item_class;
	logic [TAG_W-1:0] item_tag;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       status;
	logic [TAG_W-1:0] out_tag;
	logic             out_class;
	logic             all_empty;

	// predictor state
	slot_t            c0_slots[$];
	slot_t            c1_slots[$];
	logic [SEQ_W-1:0] next_stamp;

	fifo_resp_t  pending_resp[$];
	int unsigned results_seen;
	int unsigned mismatches;
	bit          long_hold_done;
	int          tx_calm;
	int          rx_calm;
	dir_row_t    directed_rows[12];

	two_class_fifo_oldest_first u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.item_class (item_class),
		.item_tag   (item_tag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_tag    (out_tag),
		.out_class  (out_class),
		.all_empty  (all_empty)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// gap length: mostly none or short, a few long, now and then a calm stretch
	function automatic int draw_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm = calm - 1;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// behavioural copy of the two class queues and the shared arrival counter
	function automatic fifo_resp_t predict_fifo_response(req_t req, logic cls,
			logic [TAG_W-1:0] tag);
		fifo_resp_t       r;
		slot_t            s;
		logic [SEQ_W-1:0] diff;
		int               pick;
		r.status    = STAT_OK;
		r.tag       = '0;
		r.cls       = 1'b0;
		pick        = -1;
		case (req)
			REQ_ENQ: begin
				s.tag   = tag;
				s.stamp = next_stamp;
				if ((cls ? c1_slots.size() : c0_slots.size()) >= DEPTH) begin
					// full class queue drops the item, counter holds
					r.status = STAT_FULL;
				end else begin
					if (cls)
						c1_slots.push_back(s);
					else
						c0_slots.push_back(s);
					next_stamp = next_stamp + 1'b1;
				end
			end
			REQ_DEQ_ANY: begin
				// wrap-aware age: class 0 older when the difference is negative
				if (c0_slots.size() != 0 && c1_slots.size() != 0) begin
					diff = c0_slots[0].stamp - c1_slots[0].stamp;
					pick = diff[SEQ_W-1] ? 0 : 1;
				end else if (c0_slots.size() != 0) begin
					pick = 0;
				end else if (c1_slots.size() != 0) begin
					pick = 1;
				end
			end
			REQ_DEQ_C0: begin
				if (c0_slots.size() != 0)
					pick = 0;
			end
			default: begin
				if (c1_slots.size() != 0)
					pick = 1;
			end
		endcase
		if (pick == 0) begin
			s     = c0_slots.pop_front();
			r.tag = s.tag;
		end else if (pick == 1) begin
			s     = c1_slots.pop_front();
			r.tag = s.tag;
			r.cls = 1'b1;
		end else if (req != REQ_ENQ) begin
			r.status = STAT_EMPTY;
		end
		r.all_empty = (c0_slots.size() == 0 && c1_slots.size() == 0);
		return r;
	endfunction

	// offer one request after a random gap and predict its result on transfer
	task automatic offer_request(input req_t req, input logic cls,
			input logic [TAG_W-1:0] tag, output fifo_resp_t predicted);
		int gap;
		gap = draw_gap(tx_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		req_type   = req;
		item_class = cls;
		item_tag   = tag;
		do
			@(posedge clk);
		while (in_stall);
		predicted = predict_fifo_response(req, cls, tag);
	endtask

	// result stall pattern, with one long hold-off to back the block up
	initial begin : result_stall_gen
		int hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall = 1'b0;
			end else begin
				hold = draw_gap(rx_calm);
				if (hold > 0) begin
					out_stall = 1'b1;
					repeat (hold) @(negedge clk);
				end
				out_stall = 1'b0;
			end
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		fifo_resp_t exp;
		if (arst_n && out_valid && !out_stall) begin
			results_seen = results_seen + 1;
			if (pending_resp.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result: ",
						"status %0d tag %h class %0d empty %0d",
						$realtime, status, out_tag, out_class, all_empty);
			end else begin
				exp = pending_resp.pop_front();
				if (status !== exp.status || out_tag !== exp.tag ||
						out_class !== exp.cls || all_empty !== exp.all_empty) begin
					mismatches = mismatches + 1;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result mismatch: ", $realtime,
							"exp status %0d tag %h class %0d empty %0d, ",
							exp.status, exp.tag, exp.cls, exp.all_empty,
							"got status %0d tag %h class %0d empty %0d",
							status, out_tag, out_class, all_empty);
				end
			end
		end
	end

	// stimulus
	initial begin : request_gen
		fifo_resp_t       predicted;
		req_t             req;
		logic             cls;
		logic [TAG_W-1:0] tag;
		bit               filling;
		int               r;
		in_valid       = 1'b0;
		req_type       = REQ_ENQ;
		item_class     = 1'b0;
		item_tag       = '0;
		arst_n         = 1'b0;
		next_stamp     = '0;
		results_seen   = 0;
		mismatches     = 0;
		long_hold_done = 1'b0;
		tx_calm        = 0;
		rx_calm        = 0;
		filling        = 1'b1;

		// empty pops, fill class 0 to the brim, age order across classes
		directed_rows = '{
			'{REQ_DEQ_ANY, 1'b1, 16'hBEEF, 1,  1'b1, '{STAT_EMPTY, 16'h0000, 1'b0, 1'b1}},
			'{REQ_DEQ_C0,  1'b1, 16'hFFFF, 1,  1'b1, '{STAT_EMPTY, 16'h0000, 1'b0, 1'b1}},
			'{REQ_DEQ_C1,  1'b1, 16'hFFFF, 1,  1'b1, '{STAT_EMPTY, 16'h0000, 1'b0, 1'b1}},
			'{REQ_ENQ,     1'b1, 16'h0000, 1,  1'b1, '{STAT_OK,    16'h0000, 1'b0, 1'b0}},
			'{REQ_ENQ,     1'b0, 16'hFFFF, 16, 1'b0, '{STAT_OK,    16'h0000, 1'b0, 1'b0}},
			'{REQ_ENQ,     1'b0, 16'h1234, 1,  1'b1, '{STAT_FULL,  16'h0000, 1'b0, 1'b0}},
			'{REQ_DEQ_ANY, 1'b0, 16'h0000, 1,  1'b1, '{STAT_OK,    16'h0000, 1'b1, 1'b0}},
			'{REQ_DEQ_C1,  1'b0, 16'hFFFF, 1,  1'b1, '{STAT_EMPTY, 16'h0000, 1'b0, 1'b0}},
			'{REQ_DEQ_ANY, 1'b1, 16'h0000, 1,  1'b1, '{STAT_OK,    16'hFFFF, 1'b0, 1'b0}},
			'{REQ_DEQ_C0,  1'b0, 16'h0000, 1,  1'b0, '{STAT_OK,    16'h0000, 1'b0, 1'b0}},
			'{REQ_ENQ,     1'b1, 16'hA5A5, 1,  1'b0, '{STAT_OK,    16'h0000, 1'b0, 1'b0}},
			'{REQ_DEQ_ANY, 1'b0, 16'h5A5A, 1,  1'b0, '{STAT_OK,    16'h0000, 1'b0, 1'b0}}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			for (int k = 0; k < directed_rows[i].reps; k++) begin
				offer_request(directed_rows[i].req, directed_rows[i].cls,
					directed_rows[i].tag, predicted);
				if (directed_rows[i].typed)
					pending_resp.push_back(directed_rows[i].exp);
				else
					pending_resp.push_back(predicted);
			end
		end

		// random traffic, alternating fill-heavy and drain-heavy phases
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PAUSE_AT) begin
				// sender holds back until every result is home
				@(negedge clk);
				in_valid = 1'b0;
				while (pending_resp.size() != 0)
					@(posedge clk);
			end
			if ($urandom_range(0, 39) == 0)
				filling = ~filling;
			r = $urandom_range(0, 99);
			if (r < (filling ? 65 : 25))
				req = REQ_ENQ;
			else if (r % 4 < 2)
				req = REQ_DEQ_ANY;
			else if (r % 4 == 2)
				req = REQ_DEQ_C0;
			else
				req = REQ_DEQ_C1;
			cls = 1'($urandom_range(0, 1));
			tag = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
			offer_request(req, cls, tag, predicted);
			pending_resp.push_back(predicted);
		end

		// drain and let any stray result show up
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_resp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
sv/tcf_pkg.sv
sv/tcf_ram.sv
sv/tcf_ctrl.sv
sv/tcf_datapath.sv
sv/two_class_fifo_oldest_first.sv
tb/two_class_fifo_oldest_first_tb.sv
